[rtl/bcd_pkg.sv]
`timescale 1ns / 1ps
// shared types, register codes and constants for the black corner detector
package bcd_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLACK_LEVEL  = 2'd2
    } cfg_reg_t;

    localparam int unsigned CFG_SIZE_BITS  = 12;
    localparam int unsigned PIXEL_BITS     = 8;
    localparam int unsigned COORD_BITS     = 11;

    localparam logic [CFG_SIZE_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_SIZE_BITS-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [PIXEL_BITS-1:0]    BLACK_LEVEL_RESET = 8'd50;

    // a black centre with fewer black neighbors than this is a corner
    localparam logic [3:0] CORNER_LIMIT = 4'd4;

    // window bit k*3+j: column k (0 left), row j (0 top); centre is bit 4
    localparam int unsigned CENTRE_BIT = 4;

    typedef struct packed {
        logic                  result_valid;
        logic                  is_corner;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  frame_done;
    } result_t;

    // neighbor count over the eight bits around the centre
    function automatic logic [3:0] count_neighbors(input logic [8:0] win);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != CENTRE_BIT)
            begin
                n = n + {3'd0, win[i]};
            end
        end
        return n;
    endfunction

endpackage

[rtl/bcd_line_mem.sv]
`timescale 1ns / 1ps
// two-bit-wide line store memory, one write and one registered read port
module bcd_line_mem #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    // bit 0: middle line, bit 1: upper line
    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bcd_judge.sv]
`timescale 1ns / 1ps
// 3x3 window register and corner decision for one centre pixel
module bcd_judge #(
    parameter int unsigned CW = 11,
    parameter int unsigned RW = 12,
    parameter int unsigned WW = 12,
    parameter int unsigned HW = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [CW-1:0]    col,
    input  logic [RW-1:0]    row,
    input  logic [WW-1:0]    width,
    input  logic [HW-1:0]    height,
    input  logic [2:0]       newcol,
    output bcd_pkg::result_t result
);

    logic [8:0]  window_reg;
    logic [8:0]  window_next;
    logic [8:0]  win;
    logic        at_col0;
    logic        centre_ok;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [3:0]  around;

    assign at_col0 = (col == '0);

    always_comb
    begin
        // column 0 finishes the last column of the previous row with zeros
        if (at_col0)
        begin
            win         = {3'b000, window_reg[8:3]};
            window_next = {newcol, 6'b000000};
            centre_ok   = (32'(row) >= 32'd2) && (32'(row) <= 32'(height) + 32'd1);
            cx          = 32'(width) - 32'd1;
            cy          = 32'(row) - 32'd2;
        end
        else
        begin
            win         = {newcol, window_reg[8:3]};
            window_next = win;
            centre_ok   = (32'(row) >= 32'd1) && (32'(row) <= 32'(height));
            cx          = 32'(col) - 32'd1;
            cy          = 32'(row) - 32'd1;
        end
        around = bcd_pkg::count_neighbors(win);

        result = '0;
        if (centre_ok)
        begin
            result.result_valid = 1'b1;
            result.is_corner    = win[bcd_pkg::CENTRE_BIT] &&
                                  (around < bcd_pkg::CORNER_LIMIT);
            result.pixel_x      = cx[bcd_pkg::COORD_BITS-1:0];
            result.pixel_y      = cy[bcd_pkg::COORD_BITS-1:0];
            result.frame_done   = (cx == 32'(width) - 32'd1) &&
                                  (cy == 32'(height) - 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (step)
        begin
            window_reg <= window_next;
        end
    end

endmodule

[rtl/black_corner_detect_core.sv]
`timescale 1ns / 1ps
// top level of the streaming 3x3 black corner detector
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | blue_value, green_value, red_value, flush
//  out     | out_valid / out_ready| result_valid, is_corner, pixel_x, pixel_y,
//          |                      | frame_done
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// one beat in, one beat out; a new beat is taken every cycle while out_ready does not stall
// (line store read register, then window update into the output register)
// the line store memory does one read and one write per cycle; a read that hits
// the entry written in the same cycle (one-pixel rows, or the frame's closing
// beat followed by the next frame's first) is forwarded
// after reset a clearing pass zeroes every line store entry with
// in_ready low; configuration writes are taken during it
// a stall on out_ready holds the output register and backs up into in_ready
module black_corner_detect_core #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  blue_value,
    input  logic [7:0]  green_value,
    input  logic [7:0]  red_value,
    input  logic        flush,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_valid,
    output logic        is_corner,
    output logic [10:0] pixel_x,
    output logic [10:0] pixel_y,
    output logic        frame_done,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);       // column index
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // width value
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);  // height value
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);  // row incl. flush rows

    // configuration registers
    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [7:0]  black_level_reg;

    // clamped frame size
    logic [WW-1:0] w_c;
    logic [HW-1:0] h_c;

    // line store clearing pass
    logic          clearing_reg;
    logic [CW-1:0] clr_idx_reg;

    // input position
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // stage a: position fix-up and black test
    logic [CW-1:0] col_a;
    logic [RW-1:0] row_a;
    logic [RW-1:0] row_pre;
    logic          bot_a;
    logic          in_accept;

    // stage b: line store data in hand
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_bot_reg;
    logic          s1_adv;
    logic          fwd_sel_reg;
    logic [1:0]    fwd_data_reg;
    logic [1:0]    mem_rdata;
    logic [1:0]    line_rd;
    logic [1:0]    line_wr;
    logic [2:0]    newcol;
    logic          mid_b;
    logic          top_b;

    // memory write port
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;

    // output register
    logic             out_valid_reg;
    bcd_pkg::result_t out_reg;
    bcd_pkg::result_t judge_result;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bcd_pkg::WIDTH_RESET;
            image_height_reg <= bcd_pkg::HEIGHT_RESET;
            black_level_reg  <= bcd_pkg::BLACK_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcd_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bcd_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                bcd_pkg::REG_BLACK_LEVEL:  black_level_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // out-of-range sizes clamp to 1..MAX
    always_comb
    begin
        if (image_width_reg == '0)
            w_c = WW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_c = WW'(MAX_WIDTH);
        else
            w_c = WW'(image_width_reg);

        if (image_height_reg == '0)
            h_c = HW'(1);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            h_c = HW'(MAX_HEIGHT);
        else
            h_c = HW'(image_height_reg);
    end

    // ---------------------------------------------------------------
    // clearing pass over the line store after reset
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + CW'(1);
            if (32'(clr_idx_reg) == MAX_WIDTH - 1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage a: position and black test
    // ---------------------------------------------------------------
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        // a size change mid-frame can leave the column past the row end
        if (32'(col_reg) >= 32'(w_c))
        begin
            col_a   = '0;
            row_pre = row_reg + RW'(1);
        end
        else
        begin
            col_a   = col_reg;
            row_pre = row_reg;
        end
        row_a = (32'(row_pre) > 32'(h_c) + 32'd1) ? '0 : row_pre;

        bot_a = !flush && (32'(row_a) < 32'(h_c)) &&
                (blue_value < black_level_reg) &&
                (green_value < black_level_reg) &&
                (red_value < black_level_reg);

        // the item at column 0 of the second flush row closes the frame
        if (32'(row_a) >= 32'(h_c) + 32'd1)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (32'(col_a) + 32'd1 >= 32'(w_c))
        begin
            col_next = '0;
            row_next = row_a + RW'(1);
        end
        else
        begin
            col_next = col_a + CW'(1);
            row_next = row_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                // same entry written at this edge: take the new word directly
                fwd_sel_reg  <= s1_adv && (s1_col_reg == col_a);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg   <= col_a;
            s1_row_reg   <= row_a;
            s1_bot_reg   <= bot_a;
            fwd_data_reg <= line_wr;
        end
    end

    // ---------------------------------------------------------------
    // line store
    // ---------------------------------------------------------------
    assign mem_we    = clearing_reg || s1_adv;
    assign mem_waddr = clearing_reg ? clr_idx_reg : s1_col_reg;
    assign mem_wdata = clearing_reg ? 2'b00 : line_wr;

    bcd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_accept),
        .raddr (col_a),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // stage b: new window column and line store update
    // ---------------------------------------------------------------
    always_comb
    begin
        line_rd = fwd_sel_reg ? fwd_data_reg : mem_rdata;
        // rows above the frame read as not black
        mid_b   = (32'(s1_row_reg) >= 32'd1) ? line_rd[0] : 1'b0;
        top_b   = (32'(s1_row_reg) >= 32'd2) ? line_rd[1] : 1'b0;
        newcol  = {s1_bot_reg, mid_b, top_b};
        // middle moves up unmasked, the new black bit becomes middle
        line_wr = {line_rd[0], s1_bot_reg};
    end

    bcd_judge #(
        .CW (CW),
        .RW (RW),
        .WW (WW),
        .HW (HW)
    ) u_judge (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .col    (s1_col_reg),
        .row    (s1_row_reg),
        .width  (w_c),
        .height (h_c),
        .newcol (newcol),
        .result (judge_result)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= judge_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_valid = out_reg.result_valid;
    assign is_corner    = out_reg.is_corner;
    assign pixel_x      = out_reg.pixel_x;
    assign pixel_y      = out_reg.pixel_y;
    assign frame_done   = out_reg.frame_done;

endmodule

[rtl/bcd_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the black corner detector and their binding
module bcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        result_valid,
    input logic        is_corner,
    input logic [10:0] pixel_x,
    input logic [10:0] pixel_y,
    input logic        frame_done
);

    // a waiting pixel beat stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("pixel beat withdrawn before acceptance");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_valid) &&
        $stable(is_corner) && $stable(pixel_x) && $stable(pixel_y) &&
        $stable(frame_done))
        else $error("result beat changed while stalled");

    // a beat without a centre pixel carries all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> !is_corner && !frame_done &&
        pixel_x == 11'd0 && pixel_y == 11'd0)
        else $error("empty result beat has nonzero fields");

    // frame end is only flagged on a real centre pixel
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> result_valid)
        else $error("frame_done without a centre pixel");

endmodule

bind black_corner_detect_core bcd_checker u_bcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_valid (result_valid),
    .is_corner    (is_corner),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .frame_done   (frame_done)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the streaming black corner detector core
module tb_top;

    localparam int unsigned MAX_W        = 2048;
    localparam int unsigned MAX_H        = 2048;
    localparam int unsigned RANDOM_BEATS = 330;
    localparam int unsigned EDGE_BEATS   = 150;
    // index with no register behind it, writes there must change nothing
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       flush;
    } pixel_t;

    // clock, reset and every block input start at known values
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  blue_value  = 8'd0;
    logic [7:0]  green_value = 8'd0;
    logic [7:0]  red_value   = 8'd0;
    logic        flush       = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        result_valid;
    logic        is_corner;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic        frame_done;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = 2'd0;
    logic [11:0] cfg_data    = 12'd0;

    black_corner_detect_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .blue_value   (blue_value),
        .green_value  (green_value),
        .red_value    (red_value),
        .flush        (flush),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_valid (result_valid),
        .is_corner    (is_corner),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // shadow of the register file, updated on each accepted config beat
    logic [11:0] width_reg  = bcd_pkg::WIDTH_RESET;
    logic [11:0] height_reg = bcd_pkg::HEIGHT_RESET;
    logic [7:0]  level_reg  = bcd_pkg::BLACK_LEVEL_RESET;

    // shadow of the detector state: two rows of black bits, the 3x3 window
    // and the raster position of the next pixel beat
    bit          dark_upper  [MAX_W];
    bit          dark_middle [MAX_W];
    logic [8:0]  window      = 9'd0;
    int unsigned next_col    = 0;
    int unsigned next_row    = 0;

    pixel_t           pixel_backlog [$];   // pixel beats waiting for the driver
    bcd_pkg::result_t corner_expect [$];   // predicted result beats, oldest first
    pixel_t           staged_px;

    int unsigned fail_count   = 0;
    int unsigned in_count     = 0;
    int unsigned beat_count   = 0;
    int unsigned corner_count = 0;
    int unsigned frame_count  = 0;

    // idle pattern state for the pixel sender and the result receiver
    int unsigned send_gap   = 0;
    int unsigned send_calm  = 0;
    int unsigned take_stall = 0;
    int unsigned take_calm  = 0;

    function automatic int unsigned clamp_dim(input logic [11:0] v, input int unsigned ceiling);
        if (v == 12'd0)
        begin
            return 1;
        end
        if (v > ceiling)
        begin
            return ceiling;
        end
        return v;
    endfunction

    // a size change can leave the position outside the frame; pull it back in
    function automatic void wrap_pos(inout int unsigned c, inout int unsigned r,
                                     input int unsigned w, input int unsigned h);
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r > h + 1)
        begin
            r = 0;
        end
    endfunction

    // raster advance; the frame closes one beat into row h+1
    function automatic void step_pos(inout int unsigned c, inout int unsigned r,
                                     input int unsigned w, input int unsigned h);
        if (r >= h + 1)
        begin
            c = 0;
            r = 0;
        end
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
        end
    endfunction

    // shadow of one accepted pixel beat, pushes the result it must produce
    function automatic void predict_beat(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] rv, input logic fl);
        int unsigned      w, h, c, r, cx, cy;
        logic             bot, mid, top, live;
        logic [2:0]       fresh;
        logic [8:0]       judged;
        bcd_pkg::result_t res;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = next_col;
        r = next_row;
        wrap_pos(c, r, w, h);
        // flush beats and beats below the last row never count as black
        bot = !fl && (r < h) && (b < level_reg) && (g < level_reg) && (rv < level_reg);
        // rows above the frame read as not black whatever the stores hold
        mid = (r >= 1) ? dark_middle[c] : 1'b0;
        top = (r >= 2) ? dark_upper[c] : 1'b0;
        fresh = {bot, mid, top};
        dark_upper[c]  = dark_middle[c];
        dark_middle[c] = bot;
        if (c == 0)
        begin
            // row start: the last column of the previous row is judged with
            // an empty column to its right, then the window restarts
            judged = {3'b000, window[8:3]};
            live   = (r >= 2) && (r <= h + 1);
            cx     = w - 1;
            cy     = r - 2;
            window = {fresh, 6'b000000};
        end
        else
        begin
            window = {fresh, window[8:3]};
            judged = window;
            live   = (r >= 1) && (r <= h);
            cx     = c - 1;
            cy     = r - 1;
        end
        res = '0;
        if (live)
        begin
            res.result_valid = 1'b1;
            res.is_corner    = judged[bcd_pkg::CENTRE_BIT] &&
                               ($countones(judged & 9'h1EF) < bcd_pkg::CORNER_LIMIT);
            res.pixel_x      = cx[10:0];
            res.pixel_y      = cy[10:0];
            res.frame_done   = (cx == w - 1) && (cy == h - 1);
        end
        corner_expect.push_back(res);
        step_pos(c, r, w, h);
        next_col = c;
        next_row = r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm = $urandom_range(40, 150);
            return 0;
        end
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 30);
    endfunction

    function automatic void check_field(input string label, input logic [10:0] want,
                                        input logic [10:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", label, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        bcd_pkg::result_t want;
        if (corner_expect.size() == 0)
        begin
            $error("result beat with nothing pending: x=%0d y=%0d", pixel_x, pixel_y);
            fail_count++;
            return;
        end
        want = corner_expect.pop_front();
        check_field("result_valid", want.result_valid, result_valid);
        check_field("is_corner", want.is_corner, is_corner);
        check_field("pixel_x", want.pixel_x, pixel_x);
        check_field("pixel_y", want.pixel_y, pixel_y);
        check_field("frame_done", want.frame_done, frame_done);
        beat_count++;
        if (want.result_valid && want.is_corner)
        begin
            corner_count++;
        end
        if (want.frame_done)
        begin
            frame_count++;
        end
    endfunction

    // pixel driver: a beat holds until accepted, a random gap, often empty, follows each beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            blue_value  <= 8'd0;
            green_value <= 8'd0;
            red_value   <= 8'd0;
            flush       <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(blue_value, green_value, red_value, flush);
                in_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    staged_px   = pixel_backlog.pop_front();
                    blue_value  <= staged_px.blue;
                    green_value <= staged_px.green;
                    red_value   <= staged_px.red;
                    flush       <= staged_px.flush;
                    in_valid    <= 1'b1;
                    send_gap    = pick_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each accepted beat and stalls out_ready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (take_stall > 0)
            begin
                take_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    take_stall = pick_gap(take_calm);
                end
            end
        end
    end

    // one register write; the shadow follows at the accepting edge
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bcd_pkg::REG_IMAGE_WIDTH:  width_reg  = value;
            bcd_pkg::REG_IMAGE_HEIGHT: height_reg = value;
            bcd_pkg::REG_BLACK_LEVEL:  level_reg  = value[7:0];
            default: ;
        endcase
    endtask

    // block is idle once nothing is queued, in flight, or still owed
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_backlog.size() != 0 || in_valid || corner_expect.size() != 0);
    endtask

    function automatic void add_px(input logic [7:0] b, input logic [7:0] g,
                                   input logic [7:0] rv, input logic fl);
        pixel_backlog.push_back('{b, g, rv, fl});
    endfunction

    // random pixel, black only when asked and the threshold allows it
    function automatic pixel_t shade(input bit dark);
        pixel_t      px;
        int unsigned pick;
        px.blue  = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.red   = 8'($urandom_range(0, 255));
        px.flush = 1'b0;
        if (dark && level_reg != 8'd0)
        begin
            px.blue  = 8'($urandom_range(0, level_reg - 1));
            px.green = 8'($urandom_range(0, level_reg - 1));
            px.red   = 8'($urandom_range(0, level_reg - 1));
        end
        else if (!dark)
        begin
            // one channel at or above the threshold is enough to be light
            pick = $urandom_range(0, 2);
            case (pick)
                0:       px.blue  = 8'($urandom_range(level_reg, 255));
                1:       px.green = 8'($urandom_range(level_reg, 255));
                default: px.red   = 8'($urandom_range(level_reg, 255));
            endcase
        end
        return px;
    endfunction

    // queues beats that follow the raster: pixels inside the picture and
    // flush beats after it, with a small share of misplaced ones as noise;
    // scramble drops the frame shape and picks the flush bit at random
    task automatic queue_frames(input int unsigned count, input int unsigned density,
                                input int unsigned noise, input bit scramble);
        int unsigned w, h, c, r;
        pixel_t      px;
        @(negedge clk);
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = next_col;
        r = next_row;
        for (int unsigned i = 0; i < count; i++)
        begin
            wrap_pos(c, r, w, h);
            px = shade($urandom_range(0, 99) < density);
            if (scramble)
            begin
                px.flush = 1'($urandom_range(0, 1));
            end
            else if (r < h)
            begin
                px.flush = ($urandom_range(0, 99) < noise);
            end
            else
            begin
                px.flush = ($urandom_range(0, 99) >= noise);
            end
            pixel_backlog.push_back(px);
            step_pos(c, r, w, h);
        end
    endtask

    initial
    begin : stimulus
        int unsigned roll, value, w, h, flen, count, random_n, settings_n;
        random_n   = 0;
        settings_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed frame, 4x4 at threshold 128, written during the clearing pass
        write_reg(bcd_pkg::REG_IMAGE_WIDTH, 12'd4);
        write_reg(bcd_pkg::REG_IMAGE_HEIGHT, 12'd4);
        write_reg(bcd_pkg::REG_BLACK_LEVEL, 12'd128);
        write_reg(REG_SPARE, 12'hFFF);
        @(negedge clk);
        // row 0: black corner pair, then blue alone at the threshold is light
        add_px(8'd0, 8'd0, 8'd0, 1'b0);
        add_px(8'd127, 8'd127, 8'd127, 1'b0);
        add_px(8'd128, 8'd0, 8'd0, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 1'b0);
        // row 1
        add_px(8'd0, 8'd127, 8'd0, 1'b0);
        add_px(8'd0, 8'd128, 8'd0, 1'b0);
        add_px(8'd0, 8'd0, 8'd128, 1'b0);
        add_px(8'd200, 8'd10, 8'd10, 1'b0);
        // row 2: flush inside the picture counts as light
        add_px(8'd0, 8'd0, 8'd0, 1'b1);
        add_px(8'd90, 8'd200, 8'd30, 1'b0);
        add_px(8'd0, 8'd0, 8'd0, 1'b0);
        add_px(8'd127, 8'd0, 8'd127, 1'b0);
        // row 3: 2x2 black block in the bottom right corner
        add_px(8'd255, 8'd0, 8'd0, 1'b0);
        add_px(8'd0, 8'd255, 8'd0, 1'b0);
        add_px(8'd1, 8'd2, 8'd3, 1'b0);
        add_px(8'd100, 8'd100, 8'd100, 1'b0);
        // tail: dark pixels past the frame must be taken as light
        add_px(8'd0, 8'd0, 8'd0, 1'b1);
        add_px(8'd0, 8'd0, 8'd0, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 1'b1);
        add_px(8'd0, 8'd0, 8'd0, 1'b0);
        add_px(8'd0, 8'd0, 8'd0, 1'b1);
        wait_idle();

        // widest legal row, zero height clamps to one row; start of the row only
        write_reg(bcd_pkg::REG_IMAGE_WIDTH, 12'd2048);
        write_reg(bcd_pkg::REG_IMAGE_HEIGHT, 12'd0);
        write_reg(bcd_pkg::REG_BLACK_LEVEL, 12'd255);
        queue_frames(EDGE_BEATS, 50, 3, 1'b0);
        wait_idle();

        // zero width clamps to one column, oversized height to the maximum
        write_reg(bcd_pkg::REG_IMAGE_WIDTH, 12'd0);
        write_reg(bcd_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
        write_reg(bcd_pkg::REG_BLACK_LEVEL, 12'd200);
        queue_frames(EDGE_BEATS, 50, 3, 1'b0);
        wait_idle();

        // oversized width, tallest legal frame; picks up inside the old frame
        write_reg(bcd_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(bcd_pkg::REG_IMAGE_HEIGHT, 12'd2048);
        write_reg(bcd_pkg::REG_BLACK_LEVEL, 12'd90);
        queue_frames(EDGE_BEATS, 40, 3, 1'b0);
        wait_idle();
        settings_n = 4;

        // random phases; counts often end mid-frame so the next size change
        // lands with the position inside the old frame
        while (random_n < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                roll  = $urandom_range(0, 19);
                value = (roll == 0) ? 0 : (roll < 3) ? $urandom_range(13, 48) :
                        $urandom_range(1, 12);
                write_reg(bcd_pkg::REG_IMAGE_WIDTH, value[11:0]);
            end
            if ($urandom_range(0, 99) < 70)
            begin
                roll  = $urandom_range(0, 19);
                value = (roll == 0) ? 0 : (roll < 3) ? $urandom_range(7, 20) :
                        $urandom_range(1, 6);
                write_reg(bcd_pkg::REG_IMAGE_HEIGHT, value[11:0]);
            end
            if ($urandom_range(0, 99) < 60)
            begin
                roll  = $urandom_range(0, 9);
                value = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(20, 230);
                write_reg(bcd_pkg::REG_BLACK_LEVEL, value[11:0]);
            end
            w     = clamp_dim(width_reg, MAX_W);
            h     = clamp_dim(height_reg, MAX_H);
            flen  = (h + 1) * w + 1;
            count = $urandom_range(1, 3) * flen;
            if ($urandom_range(0, 2) == 0)
            begin
                count += $urandom_range(1, flen);
            end
            // keep the random share within its budget
            if (count > RANDOM_BEATS - random_n)
            begin
                count = RANDOM_BEATS - random_n;
            end
            roll = $urandom_range(0, 2);
            queue_frames(count, (roll == 0) ? 15 : (roll == 1) ? 50 : 85, 4,
                         $urandom_range(0, 9) == 0);
            random_n += count;
            settings_n++;
            wait_idle();
        end

        // drain window, well past the pipeline
        repeat (20) @(posedge clk);
        $display("pixel beats in: %0d, results checked: %0d, corners: %0d, frames closed: %0d",
                 in_count, beat_count, corner_count, frame_count);
        $display("register settings exercised: %0d, random beats: %0d, mismatches: %0d",
                 settings_n, random_n, fail_count);
        if (fail_count == 0 && corner_expect.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/bcd_pkg.sv
rtl/bcd_line_mem.sv
rtl/bcd_judge.sv
rtl/black_corner_detect_core.sv
rtl/bcd_checker.sv
verif/tb_top.sv
